### rtl/core/c8cfr_pkg.sv
// ---------------------------------------------------------------------------
// CRC-8 command frame receiver package
// Shared types, constants and the bytewise CRC-8 update used by the
// frame receiver modules.
// ---------------------------------------------------------------------------
package c8cfr_pkg;

   // Frame layout: command byte, value byte, CRC byte.
   localparam int FRAME_BYTES = 3;
   localparam int POS_W       = 2;

   localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(0);
   localparam logic [POS_W-1:0] POS_VALUE   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

   // Command codes.
   localparam logic [7:0] CMD_THROTTLE = 8'h2A;
   localparam logic [7:0] CMD_JOYSTICK = 8'h23;

   // Reset value of the generator polynomial and the CRC start value.
   localparam logic [7:0] CRC_POLY_RESET = 8'h07;
   localparam logic [7:0] CRC_INIT       = 8'h00;

   // Fields of one response.
   typedef struct packed {
      logic [7:0] throttle_value;
      logic [7:0] joystick_value;
      logic       crc_ok;
   } result_type;

   // MSB-first CRC-8 update of one byte, no reflection, no final XOR.
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ poly;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

### rtl/core/crc8_command_frame_receiver.sv
// ---------------------------------------------------------------------------
// CRC-8 command frame receiver
// Groups received bytes into three-byte frames (command, value, CRC-8),
// checks the CRC and keeps the latest throttle and joystick values.
// ---------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the req_ channel, one per request. Counting from reset,
//   every third byte closes a frame, and each frame yields one response on
//   the rsp_ channel with the current throttle, joystick and CRC-ok flag.
//   The csr_ channel writes the CRC-8 polynomial; it is always ready and
//   should be written only while no frame is in flight.
//   A frame's last byte passes through the input register, then the
//   response register, before it shows up as a response.
//   Throughput: one byte per cycle, set by the bytewise CRC update
//   between the input register and the frame state; a closing byte
//   waits while the response register has no room.
//   Reset: position, CRC, stored values and both stages clear; the
//   polynomial returns to 0x07.
//   Stall: a held response keeps its fields; bytes that do not close a
//   frame are still taken, and a closing byte waits in the input register
//   until the response register has room.
// ---------------------------------------------------------------------------
module crc8_command_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_throttle_value,
   output logic [7:0] rsp_joystick_value,
   output logic       rsp_crc_ok,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_crc_polynomial
);

   logic                  in_valid;
   logic [7:0]            in_byte;
   logic                  in_take;
   logic                  rsp_room;
   logic                  res_valid;
   c8cfr_pkg::result_type res_data;
   c8cfr_pkg::result_type rsp_data;
   logic [7:0]            poly_ff;

   // Polynomial register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= c8cfr_pkg::CRC_POLY_RESET;
      end else if (csr_valid && csr_ready) begin
         poly_ff <= csr_crc_polynomial;
      end
   end

   c8cfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .in_valid    (in_valid),
      .in_byte     (in_byte),
      .in_take     (in_take)
   );

   c8cfr_frame_core u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .in_take   (in_take),
      .crc_poly  (poly_ff),
      .rsp_room  (rsp_room),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   c8cfr_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .rsp_room  (rsp_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_throttle_value = rsp_data.throttle_value;
   assign rsp_joystick_value = rsp_data.joystick_value;
   assign rsp_crc_ok         = rsp_data.crc_ok;

endmodule

### rtl/core/c8cfr_in_stage.sv
// ---------------------------------------------------------------------------
// Request input register
// Holds one received byte until the frame core takes it.
// ---------------------------------------------------------------------------
module c8cfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       in_valid,
   output logic [7:0] in_byte,
   input  logic       in_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // The stage can load when it is empty or its byte leaves this cycle.
   assign req_ready = !valid_ff || in_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded on each accepted request.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

### rtl/core/c8cfr_frame_core.sv
// ---------------------------------------------------------------------------
// Frame core
// Tracks the byte position, runs the CRC-8 and updates the stored
// throttle and joystick values at the end of each valid frame.
// ---------------------------------------------------------------------------
module c8cfr_frame_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   output logic                     in_take,
   input  logic [7:0]               crc_poly,
   input  logic                     rsp_room,
   output logic                     res_valid,
   output c8cfr_pkg::result_type    res_data
);

   logic [c8cfr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] value_ff, value_in;
   logic [7:0] throttle_ff, throttle_in;
   logic [7:0] joystick_ff, joystick_in;
   logic [7:0] crc_next;
   logic       last_byte;
   logic       frame_ok;

   // A byte that ends a frame waits until the response register has room.
   assign last_byte = (pos_ff == c8cfr_pkg::POS_LAST);
   assign in_take   = in_valid && (!last_byte || rsp_room);
   assign crc_next  = c8cfr_pkg::crc8_fold(crc_ff, in_byte, crc_poly);
   assign frame_ok  = (crc_next == 8'h00);

   // Next-state logic for position, CRC, the captured frame bytes and the stored values.
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      throttle_in = throttle_ff;
      joystick_in = joystick_ff;
      if (in_take) begin
         if (last_byte) begin
            pos_in = c8cfr_pkg::POS_COMMAND;
            crc_in = c8cfr_pkg::CRC_INIT;
            if (frame_ok && cmd_ff == c8cfr_pkg::CMD_THROTTLE) begin
               throttle_in = value_ff;
            end else if (frame_ok && cmd_ff == c8cfr_pkg::CMD_JOYSTICK) begin
               joystick_in = value_ff;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
            crc_in = crc_next;
            if (pos_ff == c8cfr_pkg::POS_COMMAND) begin
               cmd_in = in_byte;
            end else if (pos_ff == c8cfr_pkg::POS_VALUE) begin
               value_in = in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= c8cfr_pkg::POS_COMMAND;
         crc_ff      <= c8cfr_pkg::CRC_INIT;
         cmd_ff      <= 8'h00;
         value_ff    <= 8'h00;
         throttle_ff <= 8'h00;
         joystick_ff <= 8'h00;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         cmd_ff      <= cmd_in;
         value_ff    <= value_in;
         throttle_ff <= throttle_in;
         joystick_ff <= joystick_in;
      end
   end

   // The response carries the values as they stand after this frame.
   assign res_valid               = in_take && last_byte;
   assign res_data.throttle_value = throttle_in;
   assign res_data.joystick_value = joystick_in;
   assign res_data.crc_ok         = frame_ok;

endmodule

### rtl/core/c8cfr_rsp_stage.sv
// ---------------------------------------------------------------------------
// Response output register
// Holds one finished response until the receiver takes it.
// ---------------------------------------------------------------------------
module c8cfr_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  c8cfr_pkg::result_type res_data,
   output logic                  rsp_room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c8cfr_pkg::result_type rsp_data
);

   logic                  valid_ff, valid_in;
   c8cfr_pkg::result_type data_ff;

   // Room exists when empty or when the held response leaves this cycle.
   assign rsp_room = !valid_ff || rsp_ready;
   assign valid_in = res_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/core/c8cfr_checker.sv
// ---------------------------------------------------------------------------
// Frame receiver port checker
// Watches the top-level ports and checks response ordering rules.
// ---------------------------------------------------------------------------
module c8cfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_throttle_value,
   input logic [7:0] rsp_joystick_value,
   input logic       rsp_crc_ok
);

   logic [7:0] last_throttle_ff, last_throttle_in;
   logic [7:0] last_joystick_ff, last_joystick_in;

   // Values of the most recently delivered response, zero after reset.
   assign last_throttle_in = (rsp_valid && rsp_ready) ? rsp_throttle_value
                                                      : last_throttle_ff;
   assign last_joystick_in = (rsp_valid && rsp_ready) ? rsp_joystick_value
                                                      : last_joystick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_throttle_ff <= 8'h00;
         last_joystick_ff <= 8'h00;
      end else begin
         last_throttle_ff <= last_throttle_in;
         last_joystick_ff <= last_joystick_in;
      end
   end

   // No response is pending in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   // A stalled response keeps its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_throttle_value)
         && $stable(rsp_joystick_value) && $stable(rsp_crc_ok))
      else $error("Stalled response changed.");

   // A frame that failed its CRC leaves both stored values as they were.
   a_bad_frame_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_ok |-> rsp_throttle_value == last_throttle_ff
         && rsp_joystick_value == last_joystick_ff)
      else $error("Failed frame changed a stored value.");

   // One frame updates at most one of the two stored values.
   a_single_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_throttle_value == last_throttle_ff
         || rsp_joystick_value == last_joystick_ff)
      else $error("Both stored values changed in one frame.");

endmodule

bind crc8_command_frame_receiver c8cfr_checker u_c8cfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_throttle_value (rsp_throttle_value),
   .rsp_joystick_value (rsp_joystick_value),
   .rsp_crc_ok         (rsp_crc_ok)
);
